### design/sacm_pkg.sv
// Shared types, codes and helpers for the set-associative cache model.
// Used by every module of the block; depends on nothing else.
package sacm_pkg;

   localparam int WAY_IDX_W  = 4;
   localparam int CNT_W      = 32;
   localparam int MOVE_BYTES = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FLUSH = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      POL_LRU    = 2'd0,
      POL_FIFO   = 2'd1,
      POL_RANDOM = 2'd2,
      POL_LFU    = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_LOG2  = 3'd0,
      CSR_SET_BITS   = 3'd1,
      CSR_WAYS       = 3'd2,
      CSR_POLICY     = 3'd3,
      CSR_WRITE_BACK = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_META_RD,
      ST_SCAN,
      ST_DIVREM,
      ST_UPDATE,
      ST_DATA_RD,
      ST_FL_RD,
      ST_FL_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [CNT_W-1:0] tag;
      logic [CNT_W-1:0] stamp;
      logic [CNT_W-1:0] uses;
   } meta_entry_type;

   typedef struct packed {
      logic                 found;
      logic [WAY_IDX_W-1:0] hit_way;
      logic                 inv_found;
      logic [WAY_IDX_W-1:0] inv_way;
      logic [WAY_IDX_W-1:0] lru_way;
      logic [WAY_IDX_W-1:0] lfu_way;
   } scan_res_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

### design/sacm_scan.sv
// Way scanner: one shared tag/stamp/use comparator stepped over the ways of a set.
// Depends on sacm_pkg.
module sacm_scan import sacm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WAY_IDX_W-1:0] nw,
   input  logic [CNT_W-1:0]     tag,
   input  meta_entry_type       entry,
   output logic [WAY_IDX_W-1:0] way,
   output logic                 done,
   output scan_res_type         res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WAY_IDX_W-1:0] way_ff, way_in;
   scan_res_type         res_ff, res_in;
   logic [CNT_W-1:0]     stamp_ff, stamp_in;
   logic [CNT_W-1:0]     uses_ff, uses_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      way_in   = way_ff;
      res_in   = res_ff;
      stamp_in = stamp_ff;
      uses_in  = uses_ff;
      if (start) begin
         busy_in = 1'b1;
         way_in  = '0;
         res_in  = '0;
      end else if (busy_ff) begin
         if (entry.valid && entry.tag == tag && !res_ff.found) begin
            res_in.found   = 1'b1;
            res_in.hit_way = way_ff;
         end
         if (!entry.valid && !res_ff.inv_found) begin
            res_in.inv_found = 1'b1;
            res_in.inv_way   = way_ff;
         end
         // strict less-than keeps the lowest way on ties
         if (way_ff == '0 || entry.stamp < stamp_ff) begin
            stamp_in       = entry.stamp;
            res_in.lru_way = way_ff;
         end
         if (way_ff == '0 || entry.uses < uses_ff) begin
            uses_in        = entry.uses;
            res_in.lfu_way = way_ff;
         end
         if (way_ff == nw - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            way_in = way_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      way_ff   <= way_in;
      res_ff   <= res_in;
      stamp_ff <= stamp_in;
      uses_ff  <= uses_in;
   end

   assign way  = way_ff;
   assign done = done_ff;
   assign res  = res_ff;

endmodule

### design/sacm_divrem.sv
// Bit-serial remainder unit: 32-bit dividend modulo a small way count.
// Depends on sacm_pkg.
module sacm_divrem import sacm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CNT_W-1:0]     dividend,
   input  logic [WAY_IDX_W-1:0] divisor,
   output logic                 done,
   output logic [WAY_IDX_W-1:0] rem
);

   localparam int STEP_W = $clog2(CNT_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     shift_ff, shift_in;
   logic [WAY_IDX_W-1:0] rem_ff, rem_in;
   logic [WAY_IDX_W:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[CNT_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in   = trial[WAY_IDX_W-1:0];
         shift_in = shift_ff << 1;
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_W'(CNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### design/sacm_data.sv
// Line data store: one line per entry, byte-enabled write, registered read.
// Depends on sacm_pkg.
module sacm_data import sacm_pkg::*; #(
   parameter int LINES      = 512,
   parameter int LINE_BYTES = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(LINES > 1 ? $clog2(LINES) : 1)-1:0] wr_addr,
   input  logic [LINE_BYTES-1:0]                wr_be,
   input  logic [LINE_BYTES*8-1:0]              wr_data,
   input  logic                                 rd_en,
   input  logic [(LINES > 1 ? $clog2(LINES) : 1)-1:0] rd_addr,
   output logic [LINE_BYTES*8-1:0]              rd_data
);

   logic [LINE_BYTES*8-1:0] mem [LINES];
   logic [LINE_BYTES*8-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < LINE_BYTES; b++) begin
            if (wr_be[b]) begin
               mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/set_assoc_cache_model_core.sv
// Set-associative cache model: read, write and flush beats in, one result beat out per item.
// Depends on sacm_pkg, sacm_scan, sacm_divrem and sacm_data.
//
// One item is worked at a time. A read or write goes from the accepting cycle through
// a tag store read, one way per cycle through the shared comparator, a register for the
// scan result, an update state and a response state. A read hit adds a state to fetch
// line data. A miss under FIFO or random replacement with no free way adds the bit-serial
// remainder. A flush sweeps the tag store, reading and then clearing each set in turn.
// After reset a clearing pass over every set zeroes the tag store; no input beat is taken
// until it ends, configuration writes are.
module set_assoc_cache_model_core import sacm_pkg::*; #(
   parameter int MAX_SETS   = 64,
   parameter int MAX_WAYS   = 8,
   parameter int LINE_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: address[31:0], write_data[95:32]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,
   // req_tuser: kind[1:0]
   input  logic [1:0]            req_tuser,
   // rsp_tdata: hit[0], read_data[64:1], byte_count[68:65], evicted[69],
   // writebacks_now[79:70], reads_total[111:80], writes_total[143:112],
   // hits_total[175:144], misses_total[207:176], evictions_total[239:208],
   // writebacks_total[271:240]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [271:0]          rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NUM_LINES = MAX_SETS * MAX_WAYS;
   localparam int SET_W     = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
   localparam int LINE_W    = NUM_LINES > 1 ? $clog2(NUM_LINES) : 1;
   localparam int LB_LOG2   = $clog2(LINE_BYTES);
   localparam int SET_LOG2  = $clog2(MAX_SETS);
   localparam int OFF_W     = LB_LOG2;
   localparam int LINE_BITS = LINE_BYTES * 8;
   localparam int PCNT_W    = $clog2(MAX_WAYS + 1) > 0 ? $clog2(MAX_WAYS + 1) : 1;

   typedef meta_entry_type [MAX_WAYS-1:0] meta_row_type;

   // configuration
   logic [2:0]           lbl_ff;
   logic [2:0]           setb_ff;
   logic [3:0]           ways_ff;
   policy_type           pol_ff;
   logic                 wb_ff;

   state_type            state_ff, state_in;
   logic [SET_W-1:0]     row_ff, row_in;
   kind_type             kind_ff, kind_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [CNT_W-1:0]     tag_ff, tag_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [63:0]          wdata_ff, wdata_in;
   logic [WAY_IDX_W-1:0] nw_ff, nw_in;

   logic [CNT_W-1:0]     reads_ff, reads_in, writes_ff, writes_in;
   logic [CNT_W-1:0]     hits_ff, hits_in, misses_ff, misses_in;
   logic [CNT_W-1:0]     evicts_ff, evicts_in, wbs_ff, wbs_in;
   logic [CNT_W-1:0]     access_ff, access_in;
   logic [15:0]          lfsr_ff, lfsr_in, lfsr_next;

   logic                 hit_ff, hit_in, evicted_ff, evicted_in;
   logic [63:0]          rdata_ff, rdata_in;
   logic [9:0]           wbnow_ff, wbnow_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [271:0]         rsp_data_ff, rsp_data_in;

   // tag store
   meta_row_type         meta_mem [MAX_SETS];
   meta_row_type         meta_q;
   logic                 meta_rd_en, meta_wr_en;
   logic [SET_W-1:0]     meta_rd_addr, meta_wr_addr;
   meta_row_type         meta_wr_row;

   // data store
   logic                 data_wr_en, data_rd_en;
   logic [LINE_W-1:0]    line_addr;
   logic [LINE_BYTES-1:0] data_be;
   logic [LINE_BITS-1:0] data_wr_line, data_q, wr_shifted, rd_shifted;
   logic [LINE_BYTES-1:0] in_rng;

   // shared units
   logic                 scan_start, scan_done, mod_start, mod_done;
   logic [WAY_IDX_W-1:0] scan_way, mod_rem;
   scan_res_type         scan_res;
   logic [CNT_W-1:0]     mod_dividend;

   // request decode
   logic [31:0]          req_addr;
   kind_type             req_kind;
   logic [3:0]           ob, sb;
   logic [31:0]          lsize32, off32, set32, tag32, left32;
   logic [WAY_IDX_W-1:0] nw_calc;

   // update path
   logic [WAY_IDX_W-1:0] upd_way;
   meta_entry_type       old_e, new_e;
   logic                 is_write;
   logic [PCNT_W-1:0]    dirty_cnt;
   logic [CNT_W:0]       wb_sum;
   logic [63:0]          rd_bytes;

   assign req_addr  = req_tdata[31:0];
   assign req_kind  = kind_type'(req_tuser);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lbl_ff  <= 3'd6;
         setb_ff <= 3'd6;
         ways_ff <= 4'd8;
         pol_ff  <= POL_LRU;
         wb_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINE_LOG2:  lbl_ff  <= csr_data[2:0];
            CSR_SET_BITS:   setb_ff <= csr_data[2:0];
            CSR_WAYS:       ways_ff <= csr_data;
            CSR_POLICY:     pol_ff  <= policy_type'(csr_data[1:0]);
            CSR_WRITE_BACK: wb_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // geometry from the configuration registers, clamped to the built store
   always_comb begin
      ob      = ({1'b0, lbl_ff} > 4'(LB_LOG2)) ? 4'(LB_LOG2) : {1'b0, lbl_ff};
      sb      = ({1'b0, setb_ff} > 4'(SET_LOG2)) ? 4'(SET_LOG2) : {1'b0, setb_ff};
      lsize32 = 32'd1 << ob;
      off32   = req_addr & (lsize32 - 32'd1);
      set32   = (req_addr >> ob) & ((32'd1 << sb) - 32'd1);
      tag32   = req_addr >> (5'(ob) + 5'(sb));
      left32  = lsize32 - off32;
      if (ways_ff == 4'd0) begin
         nw_calc = 4'd1;
      end else if ({1'b0, ways_ff} > 5'(MAX_WAYS)) begin
         nw_calc = 4'(MAX_WAYS);
      end else begin
         nw_calc = ways_ff;
      end
   end

   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign is_write  = (kind_ff == KIND_WRITE);

   // victim and new entry
   always_comb begin
      if (scan_res.found) begin
         upd_way = scan_res.hit_way;
      end else if (scan_res.inv_found) begin
         upd_way = scan_res.inv_way;
      end else begin
         case (pol_ff)
            POL_LRU: upd_way = scan_res.lru_way;
            POL_LFU: upd_way = scan_res.lfu_way;
            default: upd_way = mod_rem;
         endcase
      end
      old_e = meta_q[upd_way[WAY_W-1:0]];
      new_e = old_e;
      if (scan_res.found) begin
         new_e.stamp = access_ff;
         new_e.uses  = sat_inc(old_e.uses);
         if (is_write) begin
            new_e.dirty = 1'b1;
         end
      end else begin
         new_e.valid = 1'b1;
         new_e.dirty = is_write & wb_ff;
         new_e.tag   = tag_ff;
         new_e.stamp = access_ff;
         new_e.uses  = 32'd1;
      end
   end

   // byte lanes touched by this access
   always_comb begin
      wr_shifted = LINE_BITS'(wdata_ff) << {off_ff, 3'b000};
      for (int b = 0; b < LINE_BYTES; b++) begin
         in_rng[b] = ((LB_LOG2+1)'(b) >= {1'b0, off_ff}) &&
                     ((LB_LOG2+1)'(b) < ({1'b0, off_ff} + (LB_LOG2+1)'(cnt_ff)));
      end
      rd_shifted = data_q >> {off_ff, 3'b000};
      for (int i = 0; i < MOVE_BYTES; i++) begin
         rd_bytes[i*8 +: 8] = (4'(i) < cnt_ff) ? rd_shifted[i*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      dirty_cnt = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         dirty_cnt = dirty_cnt + PCNT_W'(meta_q[w].valid & meta_q[w].dirty & wb_ff);
      end
      wb_sum = {1'b0, wbs_ff} + (CNT_W+1)'(dirty_cnt);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      kind_in      = kind_ff;
      off_in       = off_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      cnt_in       = cnt_ff;
      wdata_in     = wdata_ff;
      nw_in        = nw_ff;
      reads_in     = reads_ff;
      writes_in    = writes_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      wbs_in       = wbs_ff;
      access_in    = access_ff;
      lfsr_in      = lfsr_ff;
      hit_in       = hit_ff;
      evicted_in   = evicted_ff;
      rdata_in     = rdata_ff;
      wbnow_in     = wbnow_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      meta_rd_en   = 1'b0;
      meta_rd_addr = set_ff;
      meta_wr_en   = 1'b0;
      meta_wr_addr = row_ff;
      meta_wr_row  = '0;
      data_wr_en   = 1'b0;
      data_rd_en   = 1'b0;
      data_be      = '0;
      data_wr_line = '0;
      line_addr    = LINE_W'(32'(set_ff) * MAX_WAYS + 32'(upd_way));
      scan_start   = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = access_ff;
      case (state_ff)
         ST_CLEAR: begin
            meta_wr_en = 1'b1;
            row_in     = row_ff + 1'b1;
            if (row_ff == SET_W'(MAX_SETS - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = req_kind;
               off_in     = off32[OFF_W-1:0];
               set_in     = set32[SET_W-1:0];
               tag_in     = tag32;
               cnt_in     = (left32 > 32'(MOVE_BYTES)) ? 4'(MOVE_BYTES) : left32[3:0];
               wdata_in   = req_tdata[95:32];
               nw_in      = nw_calc;
               hit_in     = 1'b0;
               evicted_in = 1'b0;
               rdata_in   = '0;
               wbnow_in   = '0;
               case (req_kind)
                  KIND_READ, KIND_WRITE: begin
                     if (req_kind == KIND_WRITE) begin
                        writes_in = sat_inc(writes_ff);
                     end else begin
                        reads_in = sat_inc(reads_ff);
                     end
                     access_in    = sat_inc(access_ff);
                     meta_rd_en   = 1'b1;
                     meta_rd_addr = set32[SET_W-1:0];
                     state_in     = ST_META_RD;
                  end
                  KIND_FLUSH: begin
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FL_RD;
                  end
                  default: begin
                     cnt_in   = '0;
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_META_RD: begin
            scan_start = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (scan_res.found || scan_res.inv_found ||
                   pol_ff == POL_LRU || pol_ff == POL_LFU) begin
                  state_in = ST_UPDATE;
               end else begin
                  mod_start = 1'b1;
                  if (pol_ff == POL_RANDOM) begin
                     lfsr_in      = lfsr_next;
                     mod_dividend = {16'h0000, lfsr_next};
                  end
                  state_in = ST_DIVREM;
               end
            end
         end
         ST_DIVREM: begin
            if (mod_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = set_ff;
            meta_wr_row  = meta_q;
            meta_wr_row[upd_way[WAY_W-1:0]] = new_e;
            state_in     = ST_RESP;
            if (scan_res.found) begin
               hit_in  = 1'b1;
               hits_in = sat_inc(hits_ff);
               if (is_write) begin
                  data_wr_en   = 1'b1;
                  data_be      = in_rng;
                  data_wr_line = wr_shifted;
                  if (!wb_ff) begin
                     wbnow_in = 10'd1;
                     wbs_in   = sat_inc(wbs_ff);
                  end
               end else begin
                  data_rd_en = 1'b1;
                  state_in   = ST_DATA_RD;
               end
            end else begin
               misses_in = sat_inc(misses_ff);
               if (old_e.valid) begin
                  evicted_in = 1'b1;
                  evicts_in  = sat_inc(evicts_ff);
                  if (old_e.dirty && wb_ff) begin
                     wbnow_in = 10'd1;
                     wbs_in   = sat_inc(wbs_ff);
                  end
               end
               // fresh line: zero fill, write data merged in
               data_wr_en = 1'b1;
               data_be    = '1;
               for (int b = 0; b < LINE_BYTES; b++) begin
                  data_wr_line[b*8 +: 8] = (is_write && in_rng[b]) ? wr_shifted[b*8 +: 8]
                                                                   : 8'h00;
               end
               if (!is_write) begin
                  cnt_in = '0;
               end
            end
         end
         ST_DATA_RD: begin
            rdata_in = rd_bytes;
            state_in = ST_RESP;
         end
         ST_FL_RD: begin
            meta_rd_en   = 1'b1;
            meta_rd_addr = row_ff;
            state_in     = ST_FL_WR;
         end
         ST_FL_WR: begin
            meta_wr_en = 1'b1;
            wbnow_in   = wbnow_ff + 10'(dirty_cnt);
            wbs_in     = wb_sum[CNT_W] ? '1 : wb_sum[CNT_W-1:0];
            row_in     = row_ff + 1'b1;
            state_in   = ST_FL_RD;
            if (row_ff == SET_W'(MAX_SETS - 1)) begin
               row_in   = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {wbs_ff, evicts_ff, misses_ff, hits_ff, writes_ff, reads_ff,
                               wbnow_ff, evicted_ff, cnt_ff, rdata_ff, hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         wbs_ff       <= '0;
         access_ff    <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         wbs_ff       <= wbs_in;
         access_ff    <= access_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      off_ff      <= off_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      cnt_ff      <= cnt_in;
      wdata_ff    <= wdata_in;
      nw_ff       <= nw_in;
      hit_ff      <= hit_in;
      evicted_ff  <= evicted_in;
      rdata_ff    <= rdata_in;
      wbnow_ff    <= wbnow_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[meta_wr_addr] <= meta_wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_rd_en) begin
         meta_q <= meta_mem[meta_rd_addr];
      end
   end

   sacm_scan u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .nw    (nw_ff),
      .tag   (tag_ff),
      .entry (meta_q[scan_way[WAY_W-1:0]]),
      .way   (scan_way),
      .done  (scan_done),
      .res   (scan_res)
   );

   sacm_divrem u_divrem (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .divisor  (nw_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   sacm_data #(
      .LINES      (NUM_LINES),
      .LINE_BYTES (LINE_BYTES)
   ) u_data (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (line_addr),
      .wr_be   (data_be),
      .wr_data (data_wr_line),
      .rd_en   (data_rd_en),
      .rd_addr (line_addr),
      .rd_data (data_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_hit_way_in_range: assert property (@(posedge clock) disable iff (reset)
      (scan_done && scan_res.found) |-> (scan_res.hit_way < nw_ff))
      else $error("hit way beyond ways in use");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (mod_rem < nw_ff))
      else $error("remainder not below way count");

   a_access_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_READ || req_tuser == KIND_WRITE))
      |=> (state_ff == ST_META_RD))
      else $error("access beat did not start a tag lookup");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[68:65] <= 4'd8))
      else $error("byte count above eight");

endmodule
